>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

>>> design/scfm_pkg.sv
// shared types and constants of the spi command frame master
package scfm_pkg;

   localparam int unsigned SLAVE_COUNT = 5;
   localparam int unsigned SEL_W = 5;
   localparam logic [SEL_W-1:0] ALL_DESELECTED = 5'b11111;

   localparam int unsigned CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_START_MARKER = 2'd0,
      REG_POLL_CODE    = 2'd1,
      REG_REPLY_TRIES  = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_BEGIN     = 1'b0,
      CMD_XFER_DONE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_SEND    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_TYPE  = 4'd2,
      PH_ARG1  = 4'd3,
      PH_ARG2  = 4'd4,
      PH_HUNT  = 4'd5,
      PH_ECHO  = 4'd6,
      PH_DATA  = 4'd7,
      PH_CHECK = 4'd8
   } phase_type;

endpackage

>>> design/spi_command_frame_master.sv
// top level of the spi command frame master
//
// usage
//  - req channel: one transfer per item. command begin opens a frame for
//    slave 0..4 with type and two argument bytes; command transfer-done reports
//    the miso byte of the spi byte transfer that just finished
//  - rsp channel: exactly one transfer per req item, in order. kind send gives
//    the next mosi byte, kind done closes the frame with success and reply data,
//    kind ignored answers a begin while busy or a transfer-done while idle
//  - slave_select is active low, all ones when no slave is selected
//  - apb port: start_marker at 0x0, poll_code at 0x4, reply_tries at 0x8;
//    write only while no item is outstanding
// timing
//  - the result of an accepted item is registered and shown on rsp in the
//    cycle after the item is accepted
//  - throughput is one item per cycle while rsp is not stalled; the frame state and the result are
//    both computed in the single logic stage in front of the result register
// stall and reset
//  - while rsp is stalled the result register holds; req is stalled only when
//    that register is full and not being taken, so a new item enters in the
//    same cycle that the waiting result leaves
//  - synchronous reset empties the result register, returns the frame to idle
//    with all slaves deselected and loads the register reset values
module spi_command_frame_master
   import scfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [7:0]            req_slave,
   input  logic [7:0]            req_cmd_type,
   input  logic [7:0]            req_arg_first,
   input  logic [7:0]            req_arg_second,
   input  logic [7:0]            req_miso_byte,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_mosi_byte,
   output logic [SEL_W-1:0]      rsp_slave_select,
   output logic                  rsp_success,
   output logic [7:0]            rsp_reply_byte,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // configuration registers
   logic [7:0] start_marker_ff;
   logic [7:0] poll_code_ff;
   logic [2:0] reply_tries_ff;

   // frame state
   phase_type        phase_ff, phase_in;
   logic [2:0]       poll_count_ff, poll_count_in;
   logic [SEL_W-1:0] select_ff, select_in;
   logic [7:0]       sent_sum_ff, sent_sum_in;
   logic [7:0]       echo_ff, echo_in;
   logic [7:0]       data_ff, data_in;
   logic [7:0]       frame_ff [3];

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       mosi_ff, mosi_in;
   logic [SEL_W-1:0] sel_out_ff, sel_out_in;
   logic             success_ff, success_in;
   logic [7:0]       reply_ff, reply_in;

   logic             accept;
   logic             csr_write;
   logic             check_ok;
   logic [SEL_W-1:0] slave_onehot;
   reg_index_type    csr_index;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'd0;
         poll_code_ff    <= 8'd0;
         reply_tries_ff  <= 3'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_START_MARKER: start_marker_ff <= pwdata[7:0];
            REG_POLL_CODE:    poll_code_ff    <= pwdata[7:0];
            REG_REPLY_TRIES:  reply_tries_ff  <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_START_MARKER: prdata = {24'd0, start_marker_ff};
         REG_POLL_CODE:    prdata = {24'd0, poll_code_ff};
         REG_REPLY_TRIES:  prdata = {29'd0, reply_tries_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // handshake: the result register frees when empty or being taken
   // ------------------------------------------------------------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // one-hot slave decode, only the low three bits of the number count
   assign slave_onehot = {{(SEL_W-1){1'b0}}, 1'b1} << req_slave[2:0];

   // reply check at the end of the frame
   assign check_ok = (req_miso_byte == 8'(echo_ff + data_ff)) && (echo_ff == sent_sum_ff);

   // ------------------------------------------------------------------
   // frame sequencer: next state and the result of the accepted item
   // ------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      poll_count_in = poll_count_ff;
      select_in     = select_ff;
      sent_sum_in   = sent_sum_ff;
      echo_in       = echo_ff;
      data_in       = data_ff;

      // default answer: item ignored
      kind_in    = KIND_IGNORED;
      mosi_in    = 8'd0;
      sel_out_in = select_ff;
      success_in = 1'b0;
      reply_in   = 8'd0;

      if (req_command == CMD_BEGIN) begin
         if (phase_ff == PH_IDLE) begin
            if (req_slave >= 8'(SLAVE_COUNT)) begin
               // bad slave number closes the frame at once
               kind_in       = KIND_DONE;
               sel_out_in    = ALL_DESELECTED;
               select_in     = ALL_DESELECTED;
               poll_count_in = 3'd0;
            end else begin
               sent_sum_in   = 8'(req_cmd_type + req_arg_first + req_arg_second);
               select_in     = ~slave_onehot;
               poll_count_in = 3'd0;
               phase_in      = PH_START;
               kind_in       = KIND_SEND;
               mosi_in       = start_marker_ff;
               sel_out_in    = ~slave_onehot;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_START: begin
               phase_in = PH_TYPE;
               kind_in  = KIND_SEND;
               mosi_in  = frame_ff[0];
            end
            PH_TYPE: begin
               phase_in = PH_ARG1;
               kind_in  = KIND_SEND;
               mosi_in  = frame_ff[1];
            end
            PH_ARG1: begin
               phase_in = PH_ARG2;
               kind_in  = KIND_SEND;
               mosi_in  = frame_ff[2];
            end
            PH_ARG2: begin
               phase_in      = PH_HUNT;
               poll_count_in = 3'd0;
               kind_in       = KIND_SEND;
               mosi_in       = sent_sum_ff;
            end
            PH_HUNT: begin
               if (req_miso_byte == start_marker_ff) begin
                  phase_in = PH_ECHO;
                  kind_in  = KIND_SEND;
                  mosi_in  = poll_code_ff;
               end else if (poll_count_ff >= reply_tries_ff) begin
                  // no marker within the allowed polls
                  phase_in      = PH_IDLE;
                  poll_count_in = 3'd0;
                  select_in     = ALL_DESELECTED;
                  kind_in       = KIND_DONE;
                  sel_out_in    = ALL_DESELECTED;
               end else begin
                  poll_count_in = poll_count_ff + 3'd1;
                  kind_in       = KIND_SEND;
                  mosi_in       = poll_code_ff;
               end
            end
            PH_ECHO: begin
               echo_in  = req_miso_byte;
               phase_in = PH_DATA;
               kind_in  = KIND_SEND;
               mosi_in  = poll_code_ff;
            end
            PH_DATA: begin
               data_in  = req_miso_byte;
               phase_in = PH_CHECK;
               kind_in  = KIND_SEND;
               mosi_in  = poll_code_ff;
            end
            PH_CHECK: begin
               phase_in      = PH_IDLE;
               poll_count_in = 3'd0;
               select_in     = ALL_DESELECTED;
               kind_in       = KIND_DONE;
               sel_out_in    = ALL_DESELECTED;
               success_in    = check_ok;
               reply_in      = check_ok ? data_ff : 8'd0;
            end
            default: ;  // transfer done while idle is ignored
         endcase
      end

      // hold everything when no item enters
      if (!accept) begin
         phase_in      = phase_ff;
         poll_count_in = poll_count_ff;
         select_in     = select_ff;
         sent_sum_in   = sent_sum_ff;
         echo_in       = echo_ff;
         data_in       = data_ff;
      end
   end

   // ------------------------------------------------------------------
   // state registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         poll_count_ff <= 3'd0;
         select_ff     <= ALL_DESELECTED;
         sent_sum_ff   <= 8'd0;
         echo_ff       <= 8'd0;
         data_ff       <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         poll_count_ff <= poll_count_in;
         select_ff     <= select_in;
         sent_sum_ff   <= sent_sum_in;
         echo_ff       <= echo_in;
         data_ff       <= data_in;
      end
   end

   // frame bytes are written by every good begin before they are read
   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_BEGIN && phase_ff == PH_IDLE) begin
         frame_ff[0] <= req_cmd_type;
         frame_ff[1] <= req_arg_first;
         frame_ff[2] <= req_arg_second;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_in;
         mosi_ff    <= mosi_in;
         sel_out_ff <= sel_out_in;
         success_ff <= success_in;
         reply_ff   <= reply_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_mosi_byte    = mosi_ff;
   assign rsp_slave_select = sel_out_ff;
   assign rsp_success      = success_ff;
   assign rsp_reply_byte   = reply_ff;

endmodule

>>> design/scfm_checker.sv
// port-level checker for the spi command frame master and its bind
`include "assert_macros.svh"

module scfm_checker
   import scfm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_kind,
   input logic [7:0]       rsp_mosi_byte,
   input logic [SEL_W-1:0] rsp_slave_select,
   input logic             rsp_success,
   input logic [7:0]       rsp_reply_byte
);

   // a stalled result stays put
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_mosi_byte))

   // req is only held off by a full, stalled result register
   `CHK_SAME(a_no_idle_stall, clock, reset, !(rsp_valid && rsp_stall), !req_stall)

   // a finished frame has every slave deselected
   `CHK_SAME(a_done_deselect, clock, reset, rsp_valid && rsp_kind == KIND_DONE, rsp_slave_select == ALL_DESELECTED)

   // success and reply data only come with the end of a frame
   `CHK_SAME(a_success_kind, clock, reset, rsp_valid && (rsp_success || rsp_reply_byte != 8'd0), rsp_kind == KIND_DONE)

   // an accepted item always yields a result on the next cycle
   `CHK_NEXT(a_item_result, clock, reset, req_valid && !req_stall, rsp_valid)

endmodule

bind spi_command_frame_master scfm_checker u_scfm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_mosi_byte    (rsp_mosi_byte),
   .rsp_slave_select (rsp_slave_select),
   .rsp_success      (rsp_success),
   .rsp_reply_byte   (rsp_reply_byte)
);
